// File: design/adaptive_mean_threshold_assert.svh
// Assertion macros for the adaptive mean threshold block.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef ADAPTIVE_MEAN_THRESHOLD_ASSERT_SVH
`define ADAPTIVE_MEAN_THRESHOLD_ASSERT_SVH

// same-cycle implication
`define AMT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define AMT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/amt_pkg.sv
// Shared types and constants for the adaptive mean threshold block.
// No dependencies.
`default_nettype none
package amt_pkg;
    localparam int MAX_WIDTH = 1024;
    localparam int MAX_HALF  = 7;
    localparam int RING_ROWS = 2 * MAX_HALF + 2;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int SLOT_W    = $clog2(RING_ROWS);
    localparam int ADDR_W    = SLOT_W + COL_W;
    localparam int STORE_DEPTH = RING_ROWS * MAX_WIDTH;

    typedef struct packed {
        logic       action;
        logic [7:0] pixel;
    } t_in;

    typedef struct packed {
        logic [7:0] out_value;
        logic       out_last;
    } t_out;

    typedef enum logic [2:0] {
        CFG_FRAME_WIDTH  = 3'd0,
        CFG_FRAME_HEIGHT = 3'd1,
        CFG_HALF_WINDOW  = 3'd2,
        CFG_OFFSET       = 3'd3,
        CFG_MAX_VALUE    = 3'd4
    } t_cfg_idx;

    localparam logic ACT_PIXEL = 1'b0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_PIX,
        S_SCAN,
        S_LAST,
        S_MUL,
        S_FIN
    } t_state;

    typedef enum logic [1:0] {
        RD_NONE,
        RD_PIX,
        RD_SUM
    } t_rd_kind;
endpackage
`default_nettype wire

// File: design/amt_ram.sv
// Generic simple dual-port RAM with registered read.
// No dependencies.
`default_nettype none
module amt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end
endmodule
`default_nettype wire

// File: design/adaptive_mean_threshold.sv
// Adaptive mean threshold over a raster pixel stream with a bank of row stores.
// Depends on amt_pkg, amt_ram and adaptive_mean_threshold_assert.svh.
//
// Pixels are written into a ring of 16 rows held in one RAM. When a result is due,
// the clipped window is read back one pixel per cycle through the single RAM read
// port. Results wait in an output register, so the next item is taken while a
// result is still unclaimed. The row store needs no clearing.
`default_nettype none
module adaptive_mean_threshold (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire amt_pkg::t_in      i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output amt_pkg::t_out          o_out_data,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [2:0]        i_cfg_index,
    input  wire logic [12:0]       i_cfg_data
);
    localparam int CW = amt_pkg::COL_W;
    localparam int SW = amt_pkg::SLOT_W;

    amt_pkg::t_state   r_state, n_state;
    amt_pkg::t_rd_kind r_kind, n_kind;

    logic [10:0] r_fw;
    logic [12:0] r_fh;
    logic [2:0]  r_half;
    logic [12:0] r_off;
    logic [7:0]  r_max;

    logic [CW-1:0] r_in_col, n_in_col;
    logic [SW-1:0] r_in_slot, n_in_slot;
    logic [CW-1:0] r_out_col, n_out_col;
    logic [12:0]   r_out_row, n_out_row;
    logic [SW-1:0] r_out_slot, n_out_slot;
    logic [15:0]   r_backlog, n_backlog;

    logic [12:0]   r_y, n_y, r_r1, n_r1;
    logic [CW-1:0] r_x, n_x, r_c0, n_c0, r_c1, n_c1;
    logic          r_empty, n_empty, r_pix_ok, n_pix_ok;
    logic [15:0]   r_sum, n_sum;
    logic [7:0]    r_count, n_count;
    logic [7:0]    r_pix, n_pix;
    logic [15:0]   r_p1, n_p1;
    logic [21:0]   r_p2, n_p2;

    logic          r_out_v, n_out_v;
    amt_pkg::t_out r_out, n_out;

    logic              wr_en, rd_en;
    logic [amt_pkg::ADDR_W-1:0] wr_addr, rd_addr;
    logic [7:0]        rd_data;

    // effective sizes
    logic [10:0] w_eff, wm1;
    logic [12:0] ht_eff, htm1;
    logic [2:0]  h_eff;
    logic [13:0] r_plus_h, nr;
    logic [10:0] c_plus_h, nc;
    logic [12:0] r0;
    logic [CW-1:0] c0;
    logic signed [14:0] dr;
    logic signed [11:0] dc;
    logic signed [27:0] reach;
    logic          due;
    logic [SW-1:0] scan_slot;
    logic signed [23:0] lhs, rhs;
    logic          out_take, load;

    always_comb begin
        w_eff  = (r_fw == 11'd0) ? 11'd1 :
                 (r_fw > 11'(amt_pkg::MAX_WIDTH)) ? 11'(amt_pkg::MAX_WIDTH) : r_fw;
        wm1    = w_eff - 11'd1;
        ht_eff = (r_fh == 13'd0) ? 13'd1 : r_fh;
        htm1   = ht_eff - 13'd1;
        h_eff  = (r_half > 3'(amt_pkg::MAX_HALF)) ? 3'(amt_pkg::MAX_HALF) : r_half;

        r_plus_h = {1'b0, r_out_row} + {11'd0, h_eff};
        nr       = (r_plus_h > {1'b0, htm1}) ? {1'b0, htm1} : r_plus_h;
        c_plus_h = {1'b0, r_out_col} + {8'd0, h_eff};
        nc       = (c_plus_h > wm1) ? wm1 : c_plus_h;
        r0       = (r_out_row >= {10'd0, h_eff}) ? r_out_row - {10'd0, h_eff} : 13'd0;
        c0       = (r_out_col >= CW'(h_eff)) ? r_out_col - CW'(h_eff) : '0;
        dr       = $signed({1'b0, nr}) - $signed({2'b0, r_out_row});
        dc       = $signed({1'b0, nc}) - $signed({2'b0, r_out_col});
        reach    = 28'(dr * $signed({1'b0, w_eff})) + 28'(dc);
        due      = (r_backlog != 16'd0) && ($signed({12'd0, r_backlog}) > reach);

        scan_slot = r_out_slot + r_y[SW-1:0] - r_out_row[SW-1:0];

        lhs = $signed({4'd0, r_p1, 4'd0});
        rhs = $signed({4'd0, r_sum, 4'd0}) - $signed({{2{r_p2[21]}}, r_p2});
    end

    // configuration
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw   <= 11'd640;
            r_fh   <= 13'd480;
            r_half <= 3'd5;
            r_off  <= 13'd32;
            r_max  <= 8'd255;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                amt_pkg::CFG_FRAME_WIDTH:  r_fw   <= i_cfg_data[10:0];
                amt_pkg::CFG_FRAME_HEIGHT: r_fh   <= i_cfg_data;
                amt_pkg::CFG_HALF_WINDOW:  r_half <= i_cfg_data[2:0];
                amt_pkg::CFG_OFFSET:       r_off  <= i_cfg_data;
                amt_pkg::CFG_MAX_VALUE:    r_max  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign o_in_ready  = (r_state == amt_pkg::S_IDLE);
    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;
    assign out_take    = r_out_v && i_out_ready;
    assign load        = (r_state == amt_pkg::S_FIN) && (!r_out_v || i_out_ready);

    always_comb begin
        n_state    = r_state;
        n_kind     = amt_pkg::RD_NONE;
        n_in_col   = r_in_col;
        n_in_slot  = r_in_slot;
        n_out_col  = r_out_col;
        n_out_row  = r_out_row;
        n_out_slot = r_out_slot;
        n_backlog  = r_backlog;
        n_y        = r_y;
        n_x        = r_x;
        n_r1       = r_r1;
        n_c0       = r_c0;
        n_c1       = r_c1;
        n_empty    = r_empty;
        n_pix_ok   = r_pix_ok;
        n_sum      = r_sum;
        n_count    = r_count;
        n_pix      = r_pix;
        n_p1       = r_p1;
        n_p2       = r_p2;
        n_out_v    = out_take ? 1'b0 : r_out_v;
        n_out      = r_out;
        wr_en      = 1'b0;
        wr_addr    = {r_in_slot, r_in_col};
        rd_en      = 1'b0;
        rd_addr    = {r_out_slot, r_out_col};

        // absorb read data from the previous cycle
        case (r_kind)
            amt_pkg::RD_PIX: n_pix = r_pix_ok ? rd_data : 8'd0;
            amt_pkg::RD_SUM: begin
                n_sum   = r_sum + {8'd0, rd_data};
                n_count = r_count + 8'd1;
            end
            default: ;
        endcase

        case (r_state)
            amt_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_data.action == amt_pkg::ACT_PIXEL) begin
                        wr_en = 1'b1;
                        if ({1'b0, r_in_col} >= wm1) begin
                            n_in_col  = '0;
                            n_in_slot = r_in_slot + SW'(1);
                        end else begin
                            n_in_col = r_in_col + CW'(1);
                        end
                        n_backlog = r_backlog + 16'd1;
                    end
                    n_state = amt_pkg::S_CHECK;
                end
            end
            amt_pkg::S_CHECK: begin
                n_y      = r0;
                n_r1     = nr[12:0];
                n_x      = c0;
                n_c0     = c0;
                n_c1     = nc[CW-1:0];
                n_empty  = (r0 > nr[12:0]) || (c0 > nc[CW-1:0]);
                n_pix_ok = (r_out_row < ht_eff) && ({1'b0, r_out_col} < w_eff);
                n_sum    = 16'd0;
                n_count  = 8'd0;
                n_state  = due ? amt_pkg::S_PIX : amt_pkg::S_IDLE;
            end
            amt_pkg::S_PIX: begin
                rd_en   = 1'b1;
                n_kind  = amt_pkg::RD_PIX;
                n_state = r_empty ? amt_pkg::S_LAST : amt_pkg::S_SCAN;
            end
            amt_pkg::S_SCAN: begin
                rd_en   = 1'b1;
                rd_addr = {scan_slot, r_x};
                n_kind  = amt_pkg::RD_SUM;
                if (r_x == r_c1) begin
                    n_x = r_c0;
                    if (r_y == r_r1) begin
                        n_state = amt_pkg::S_LAST;
                    end else begin
                        n_y = r_y + 13'd1;
                    end
                end else begin
                    n_x = r_x + CW'(1);
                end
            end
            amt_pkg::S_LAST: begin
                n_state = amt_pkg::S_MUL;
            end
            amt_pkg::S_MUL: begin
                n_p1    = r_pix * {8'd0, r_count};
                n_p2    = 22'($signed(r_off) * $signed({1'b0, r_count}));
                n_state = amt_pkg::S_FIN;
            end
            amt_pkg::S_FIN: begin
                if (load) begin
                    n_out_v           = 1'b1;
                    n_out.out_value   = (lhs < rhs) ? r_max : 8'd0;
                    n_out.out_last    = (r_out_row == htm1) && ({1'b0, r_out_col} == wm1);
                    if ({1'b0, r_out_col} >= wm1) begin
                        n_out_col  = '0;
                        n_out_slot = r_out_slot + SW'(1);
                        n_out_row  = (r_out_row >= htm1) ? 13'd0 : r_out_row + 13'd1;
                    end else begin
                        n_out_col = r_out_col + CW'(1);
                    end
                    n_backlog = r_backlog - 16'd1;
                    n_state   = amt_pkg::S_IDLE;
                end
            end
            default: n_state = amt_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= amt_pkg::S_IDLE;
            r_kind     <= amt_pkg::RD_NONE;
            r_in_col   <= '0;
            r_in_slot  <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_out_slot <= '0;
            r_backlog  <= '0;
            r_out_v    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_kind     <= n_kind;
            r_in_col   <= n_in_col;
            r_in_slot  <= n_in_slot;
            r_out_col  <= n_out_col;
            r_out_row  <= n_out_row;
            r_out_slot <= n_out_slot;
            r_backlog  <= n_backlog;
            r_out_v    <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_y      <= n_y;
        r_r1     <= n_r1;
        r_x      <= n_x;
        r_c0     <= n_c0;
        r_c1     <= n_c1;
        r_empty  <= n_empty;
        r_pix_ok <= n_pix_ok;
        r_sum    <= n_sum;
        r_count  <= n_count;
        r_pix    <= n_pix;
        r_p1     <= n_p1;
        r_p2     <= n_p2;
        r_out    <= n_out;
    end

    amt_ram #(
        .WIDTH(8),
        .DEPTH(amt_pkg::STORE_DEPTH)
    ) u_row_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_in_data.pixel),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

`include "adaptive_mean_threshold_assert.svh"

    `AMT_ASSERT_NEXT(a_accept_checks, i_in_valid && o_in_ready, r_state == amt_pkg::S_CHECK, "accepted transfer did not go to check")
    `AMT_ASSERT_NOW(a_emit_has_backlog, r_state == amt_pkg::S_PIX, r_backlog != 16'd0, "result started with empty backlog")
    `AMT_ASSERT_NEXT(a_load_sets_valid, load, r_out_v, "result load lost")
    `AMT_ASSERT_NOW(a_no_write_on_scan, rd_en, !wr_en, "row store read and written together")

endmodule
`default_nettype wire

// File: bench/tb_adaptive_mean_threshold.sv
// Self-checking bench for adaptive_mean_threshold: random pixel frames, drains and register
// phases, with results compared against an in-bench threshold predictor.
// Depends on amt_pkg and the adaptive_mean_threshold RTL.
`default_nettype none
module tb_adaptive_mean_threshold;

    localparam int RING = 2 * amt_pkg::MAX_HALF + 2;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          in_valid = 1'b0;
    logic          in_ready;
    amt_pkg::t_in  in_data = '0;
    logic          out_valid;
    logic          out_ready = 1'b0;
    amt_pkg::t_out out_data;
    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    logic [2:0]    cfg_index = '0;
    logic [12:0]   cfg_data = '0;

    adaptive_mean_threshold DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // threshold predictor state
    logic [7:0]         pix_ring [RING * amt_pkg::MAX_WIDTH];
    int                 in_col, in_row, out_col, out_row, in_slot, out_slot, backlog;
    logic [10:0]        reg_width;
    logic [12:0]        reg_height;
    logic [2:0]         reg_half;
    logic signed [12:0] reg_offset;
    logic [7:0]         reg_max;

    amt_pkg::t_in  pending_pixels [$];
    amt_pkg::t_out expected_levels [$];
    int   mismatches = 0;
    int   items_queued = 0;
    bit   paused_once = 1'b0;
    bit   no_idle = 0;
    int   in_gap = 0;
    int   out_stall = 0;

    function automatic int eff_w();
        if (reg_width == 0) return 1;
        if (reg_width > amt_pkg::MAX_WIDTH) return amt_pkg::MAX_WIDTH;
        return int'(reg_width);
    endfunction

    function automatic int eff_h();
        return (reg_height == 0) ? 1 : int'(reg_height);
    endfunction

    function automatic int eff_half();
        return (reg_half > amt_pkg::MAX_HALF) ? amt_pkg::MAX_HALF : int'(reg_half);
    endfunction

    function automatic int draw_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    function automatic void apply_reg(amt_pkg::t_cfg_idx idx, logic [12:0] val);
        case (idx)
            amt_pkg::CFG_FRAME_WIDTH:  reg_width  = val[10:0];
            amt_pkg::CFG_FRAME_HEIGHT: reg_height = val;
            amt_pkg::CFG_HALF_WINDOW:  reg_half   = val[2:0];
            amt_pkg::CFG_OFFSET:       reg_offset = signed'(val);
            amt_pkg::CFG_MAX_VALUE:    reg_max    = val[7:0];
            default: ;
        endcase
    endfunction

    // Advance the predictor by one accepted item; queue the released level, if any.
    function automatic void threshold_step(amt_pkg::t_in it);
        int w, ht, h, nr, nc, r0, r1, c0, c1, slot;
        longint sum, cnt, pix;
        amt_pkg::t_out res;
        w  = eff_w();
        ht = eff_h();
        h  = eff_half();
        if (it.action == amt_pkg::ACT_PIXEL) begin
            if (in_col < amt_pkg::MAX_WIDTH)
                pix_ring[(in_slot % RING) * amt_pkg::MAX_WIDTH + in_col] = it.pixel;
            if (in_col >= w - 1) begin
                in_col  = 0;
                in_slot = (in_slot + 1) % RING;
                in_row  = (in_row >= ht - 1) ? 0 : in_row + 1;
            end else begin
                in_col++;
            end
            backlog++;
        end
        nr = (out_row + h > ht - 1) ? ht - 1 : out_row + h;
        nc = (out_col + h > w - 1) ? w - 1 : out_col + h;
        if (!(backlog > 0 && backlog > (nr - out_row) * w + (nc - out_col))) return;
        r0 = (out_row - h < 0) ? 0 : out_row - h;
        r1 = nr;
        c0 = (out_col - h < 0) ? 0 : out_col - h;
        c1 = nc;
        sum = 0;
        cnt = 0;
        pix = 0;
        for (int y = r0; y <= r1; y++) begin
            slot = (out_slot + RING + (y - out_row)) % RING;
            for (int x = c0; x <= c1; x++) begin
                sum += pix_ring[slot * amt_pkg::MAX_WIDTH + x];
                cnt++;
            end
        end
        if (out_row < ht && out_col < w)
            pix = pix_ring[(out_slot % RING) * amt_pkg::MAX_WIDTH + out_col];
        res.out_value = (16 * pix * cnt < 16 * sum - longint'(reg_offset) * cnt) ? reg_max : 8'd0;
        res.out_last  = (out_row == ht - 1 && out_col == w - 1);
        expected_levels = {expected_levels, res};
        if (out_col >= w - 1) begin
            out_col  = 0;
            out_slot = (out_slot + 1) % RING;
            out_row  = (out_row >= ht - 1) ? 0 : out_row + 1;
        end else begin
            out_col++;
        end
        backlog--;
    endfunction

    // pixel driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) threshold_step(in_data);
            if (in_valid && !in_ready) begin
                // hold the pending transfer
            end else if (in_gap > 0) begin
                in_gap   <= in_gap - 1;
                in_valid <= 1'b0;
            end else if (pending_pixels.size() > 0) begin
                in_data  <= pending_pixels.pop_front();
                in_valid <= 1'b1;
                in_gap   <= draw_gap();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        amt_pkg::t_out exp_lvl;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_levels.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result value=%0d last=%0b",
                                 out_data.out_value, out_data.out_last);
                end else begin
                    exp_lvl = expected_levels.pop_front();
                    if (exp_lvl != out_data) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected value=%0d last=%0b, got value=%0d last=%0b",
                                     exp_lvl.out_value, exp_lvl.out_last,
                                     out_data.out_value, out_data.out_last);
                    end
                end
            end
            if (out_stall > 0) begin
                out_stall <= out_stall - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
                out_stall <= draw_gap();
            end
        end
    end

    task automatic wait_quiet();
        while (pending_pixels.size() > 0 || in_valid || expected_levels.size() > 0)
            @(posedge i_clk);
    endtask

    // Wait until nothing is pending or expected, then let the block run on idle.
    task automatic wait_idle();
        wait_quiet();
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_reg(amt_pkg::t_cfg_idx idx, logic [12:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!cfg_ready);
        apply_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_all(int w, int ht, int h, int off, int mx);
        write_reg(amt_pkg::CFG_FRAME_WIDTH, 13'(w));
        write_reg(amt_pkg::CFG_FRAME_HEIGHT, 13'(ht));
        write_reg(amt_pkg::CFG_HALF_WINDOW, 13'(h));
        write_reg(amt_pkg::CFG_OFFSET, 13'(off));
        write_reg(amt_pkg::CFG_MAX_VALUE, 13'(mx));
    endtask

    function automatic void push_item(bit drain, logic [7:0] px);
        amt_pkg::t_in it;
        it.action = drain ? ~amt_pkg::ACT_PIXEL : amt_pkg::ACT_PIXEL;
        it.pixel  = px;
        pending_pixels = {pending_pixels, it};
        items_queued++;
    endfunction

    // enough drains to flush the deepest backlog the current frame shape allows
    function automatic void push_drains();
        int n, rows;
        rows = (eff_half() < eff_h() - 1) ? eff_half() : eff_h() - 1;
        n = rows * eff_w() + eff_half() + 2;
        for (int i = 0; i < n; i++) push_item(1'b1, 8'($urandom));
    endfunction

    function automatic logic [7:0] draw_pixel(int style, int x, int y);
        int v;
        case (style)
            0: return 8'($urandom);
            1: begin
                v = x * 9 + y * 5 + $urandom_range(0, 24) - 12;
                return (v < 0) ? 8'd0 : (v > 255 ? 8'd255 : 8'(v));
            end
            default: return $urandom_range(1) ? 8'd255 : 8'd0;
        endcase
    endfunction

    // Queue one frame; optionally hold the sender midway until all results are in.
    task automatic send_frame(bit pause_mid);
        int style, w, ht;
        style = $urandom_range(2);
        w  = eff_w();
        ht = eff_h();
        for (int y = 0; y < ht; y++) begin
            for (int x = 0; x < w; x++) begin
                if ($urandom_range(99) < 4) push_item(1'b1, 8'($urandom));
                push_item(1'b0, draw_pixel(style, x, y));
                if (pause_mid && y == ht / 2 && x == w / 2) wait_quiet();
            end
        end
    endtask

    int w_pick, h_pick;

    initial begin
        reg_width  = 11'd640;
        reg_height = 13'd480;
        reg_half   = 3'd5;
        reg_offset = 13'sd32;
        reg_max    = 8'd255;
        in_col = 0; in_row = 0; out_col = 0; out_row = 0;
        in_slot = 0; out_slot = 0; backlog = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: 3x3 frame, extreme pixels, drain with nothing pending
        write_all(3, 3, 1, 0, 255);
        push_item(1'b1, 8'd0);
        push_item(1'b0, 8'd0);
        push_item(1'b0, 8'd255);
        push_item(1'b0, 8'd0);
        push_item(1'b0, 8'd255);
        push_item(1'b0, 8'd128);
        push_item(1'b0, 8'd1);
        push_item(1'b0, 8'd254);
        push_item(1'b0, 8'd0);
        push_item(1'b0, 8'd255);
        push_drains();
        wait_idle();

        // widest row, largest window, most negative offset, zero level
        write_all(2047, 1, 7, -4096, 0);
        send_frame(1'b0);
        push_drains();
        wait_idle();
        // a height of 4096 is written and replaced by zero; the width is written as zero
        write_reg(amt_pkg::CFG_FRAME_HEIGHT, 13'd4096);
        write_reg(amt_pkg::CFG_FRAME_WIDTH, 13'd0);
        write_reg(amt_pkg::CFG_FRAME_HEIGHT, 13'd0);
        write_reg(amt_pkg::CFG_OFFSET, 13'(4095));
        send_frame(1'b0);
        push_drains();
        wait_idle();

        while (items_queued < 1850) begin
            case ($urandom_range(5))
                0: w_pick = 1;
                1: w_pick = 2;
                default: w_pick = $urandom_range(3, 24);
            endcase
            h_pick = ($urandom_range(4) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 12);
            case ($urandom_range(3))
                0: write_all(w_pick, h_pick, $urandom_range(7), $urandom_range(0, 8191) - 4096,
                             $urandom_range(255));
                1: write_all(w_pick, h_pick, $urandom_range(7), $urandom_range(0, 128) - 64,
                             255);
                2: write_all(w_pick, h_pick, $urandom_range(7), 4095, $urandom_range(255));
                default: write_all(w_pick, h_pick, $urandom_range(7), -4096, $urandom_range(255));
            endcase
            no_idle = ($urandom_range(4) == 0);
            for (int f = $urandom_range(1, 3); f > 0; f--) begin
                send_frame($urandom_range(9) == 0 || !paused_once);
                paused_once = 1'b1;
                // choose at random between draining and running straight into the next frame
                if ($urandom_range(1)) push_drains();
            end
            push_drains();
            wait_idle();
        end

        wait_quiet();
        repeat (300) @(posedge i_clk);
        if (mismatches == 0 && expected_levels.size() == 0) begin
            $display("tb_adaptive_mean_threshold: clean");
        end else begin
            $display("tb_adaptive_mean_threshold: errors");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("tb_adaptive_mean_threshold: errors");
        $finish;
    end
endmodule
`default_nettype wire

// File: sim.f
+incdir+design
design/amt_pkg.sv
design/amt_ram.sv
design/adaptive_mean_threshold.sv
bench/tb_adaptive_mean_threshold.sv
